@@ hw/rtl/sth_pkg.sv @@
`default_nettype none

package sth_pkg;

    localparam int HASH_W = 64;
    localparam int BYTE_W = 8;

    // jenkins one-at-a-time shift amounts
    localparam int MIX_SHL = 10;
    localparam int MIX_SHR = 6;
    localparam int FIN_SHL_A = 3;
    localparam int FIN_SHR = 11;
    localparam int FIN_SHL_B = 15;

    typedef logic [HASH_W-1:0] hash_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // token close event handed from the token stage to the vote stage
    typedef struct packed {
        hash_t hash;   // raw running hash, not yet finalized
        logic  vote;   // a token closed, counters take a vote
        logic  last;   // end of text, fingerprint follows
    } sth_close_t;

    function automatic logic is_word_char(input byte_t c);
        logic lower;
        logic upper;
        logic digit;
        lower = (c >= 8'h61) && (c <= 8'h7a);
        upper = (c >= 8'h41) && (c <= 8'h5a);
        digit = (c >= 8'h30) && (c <= 8'h39);
        return lower || upper || digit;
    endfunction

    function automatic hash_t oaat_mix(input hash_t h, input byte_t c);
        hash_t t;
        t = h + hash_t'(c);
        t = t + (t << MIX_SHL);
        t = t ^ (t >> MIX_SHR);
        return t;
    endfunction

    function automatic hash_t oaat_final(input hash_t h);
        hash_t t;
        t = h + (h << FIN_SHL_A);
        t = t ^ (t >> FIN_SHR);
        t = t + (t << FIN_SHL_B);
        return t;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/simhash_text_fingerprint.sv @@
`default_nettype none

// simhash text fingerprint, one text byte per word on the input channel
//
// s_ channel: s_text_byte carries one byte of text, s_end_of_text marks the
// final byte. letters and digits build a token (first MAX_TOKEN_CHARS count),
// any other byte closes it; each closed token votes its finalized 64-bit
// one-at-a-time hash into 64 saturating counters of VOTE_WIDTH bits.
// m_ channel: m_fingerprint, one word per text, bit i set where counter i
// is positive; all counters and token state clear after it.
//
// path: the last byte passes the input register, the token event register
// and the output register before the fingerprint is valid
// throughput: 1 byte per cycle unless stalled, set by the hash update loop
// reset (aresetn low, synchronous) empties the pipe and clears all state
// stall: while a fingerprint waits, bytes keep flowing; the pipe holds only
// when the next end-of-text reaches the vote stage with the output still full

module simhash_text_fingerprint #(
    parameter int MAX_TOKEN_CHARS = 127,
    parameter int VOTE_WIDTH      = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_text_byte,
    input  wire logic        s_end_of_text,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_fingerprint
);

    // token close events between the hash stage and the vote stage
    logic                ev_valid;
    logic                ev_ready;
    sth_pkg::sth_close_t ev;

    sth_token #(
        .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
    ) u_token (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .ev_valid      (ev_valid),
        .ev_ready      (ev_ready),
        .ev            (ev)
    );

    // finalize, vote and hold the fingerprint word
    sth_vote #(
        .VOTE_WIDTH(VOTE_WIDTH)
    ) u_vote (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ev_valid      (ev_valid),
        .ev_ready      (ev_ready),
        .ev            (ev),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_fingerprint (m_fingerprint)
    );

endmodule

`default_nettype wire

@@ hw/rtl/sth_token.sv @@
`default_nettype none

module sth_token #(
    parameter int MAX_TOKEN_CHARS = 127
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_text_byte,
    input  wire logic                s_end_of_text,
    output logic                     ev_valid,
    input  wire logic                ev_ready,
    output sth_pkg::sth_close_t      ev
);

    localparam int LEN_W = $clog2(MAX_TOKEN_CHARS + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_CHARS);

    // input register
    logic                a_valid_reg;
    logic                a_valid_next;
    sth_pkg::byte_t      a_byte_reg;
    logic                a_last_reg;
    logic                a_fire;
    logic                ev_free;

    // token state
    sth_pkg::hash_t      hash_reg;
    sth_pkg::hash_t      hash_next;
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    len_next;

    // event register
    logic                ev_valid_reg;
    logic                ev_valid_next;
    sth_pkg::sth_close_t ev_reg;
    sth_pkg::sth_close_t ev_next;

    logic                word;
    logic                grow;
    logic                close_now;
    sth_pkg::hash_t      grown_hash;

    assign ev_free = !ev_valid_reg || ev_ready;
    assign a_fire  = a_valid_reg && ev_free;
    assign s_ready = !a_valid_reg || a_fire;

    assign a_valid_next = (s_valid && s_ready) ? 1'b1 : (a_fire ? 1'b0 : a_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_byte_reg <= s_text_byte;
            a_last_reg <= s_end_of_text;
        end
    end

    // hash update and token close for the byte in the input register
    always_comb begin
        word       = sth_pkg::is_word_char(a_byte_reg);
        grow       = word && (len_reg < LEN_MAX);
        grown_hash = grow ? sth_pkg::oaat_mix(hash_reg, a_byte_reg) : hash_reg;
        // a word byte always leaves a non-empty token behind it
        close_now  = (!word && (len_reg != '0)) || (a_last_reg && word);

        hash_next = hash_reg;
        len_next  = len_reg;
        if (a_fire) begin
            if (close_now || a_last_reg) begin
                hash_next = '0;
                len_next  = '0;
            end else if (grow) begin
                hash_next = grown_hash;
                len_next  = len_reg + LEN_W'(1);
            end
        end

        ev_next.hash = grown_hash;
        ev_next.vote = close_now;
        ev_next.last = a_last_reg;

        if (ev_free) begin
            ev_valid_next = a_fire && (close_now || a_last_reg);
        end else begin
            ev_valid_next = ev_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg     <= '0;
            len_reg      <= '0;
            ev_valid_reg <= 1'b0;
        end else begin
            hash_reg     <= hash_next;
            len_reg      <= len_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_fire) begin
            ev_reg <= ev_next;
        end
    end

    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_MAX)
        else $error("token length past limit");

    a_empty_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg == '0) |-> (hash_reg == '0))
        else $error("hash nonzero with no open token");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_fire && a_last_reg) |=> (len_reg == '0 && hash_reg == '0 && ev_valid_reg))
        else $error("end of text left token state or no event");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/sth_vote.sv @@
`default_nettype none

module sth_vote #(
    parameter int VOTE_WIDTH = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                ev_valid,
    output logic                     ev_ready,
    input  wire sth_pkg::sth_close_t ev,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [63:0]              m_fingerprint
);

    localparam int NV = sth_pkg::HASH_W;
    localparam logic signed [VOTE_WIDTH-1:0] VOTE_MAX = {1'b0, {(VOTE_WIDTH-1){1'b1}}};
    localparam logic signed [VOTE_WIDTH-1:0] VOTE_MIN = {1'b1, {(VOTE_WIDTH-1){1'b0}}};
    localparam logic signed [VOTE_WIDTH-1:0] VOTE_ONE = {{(VOTE_WIDTH-1){1'b0}}, 1'b1};

    logic signed [VOTE_WIDTH-1:0] vote_reg  [NV];
    logic signed [VOTE_WIDTH-1:0] vote_next [NV];
    logic signed [VOTE_WIDTH-1:0] vote_upd  [NV];
    sth_pkg::hash_t               fin_hash;
    sth_pkg::hash_t               fp_next;
    logic                         fire;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    sth_pkg::hash_t               m_fp_reg;

    // only a word that ends a text needs room in the output register
    assign ev_ready = !ev.last || !m_valid_reg || m_ready;
    assign fire     = ev_valid && ev_ready;

    always_comb begin
        fin_hash = sth_pkg::oaat_final(ev.hash);
        for (int i = 0; i < NV; i++) begin
            vote_upd[i] = vote_reg[i];
            if (ev.vote) begin
                if (fin_hash[i]) begin
                    if (vote_reg[i] != VOTE_MAX) vote_upd[i] = vote_reg[i] + VOTE_ONE;
                end else begin
                    if (vote_reg[i] != VOTE_MIN) vote_upd[i] = vote_reg[i] - VOTE_ONE;
                end
            end
            fp_next[i]   = !vote_upd[i][VOTE_WIDTH-1] && (vote_upd[i] != '0);
            vote_next[i] = vote_reg[i];
            if (fire) begin
                vote_next[i] = ev.last ? '0 : vote_upd[i];
            end
        end
    end

    assign m_valid_next = (fire && ev.last) ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NV; i++) begin
                vote_reg[i] <= '0;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < NV; i++) begin
                vote_reg[i] <= vote_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && ev.last) begin
            m_fp_reg <= fp_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_fingerprint = m_fp_reg;

`ifndef NO_ASSERTIONS
    a_last_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ev.last) |=> m_valid_reg)
        else $error("end of text gave no fingerprint");

    a_votes_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ev.last) |=> (vote_reg[0] == '0 && vote_reg[NV-1] == '0))
        else $error("vote counters not cleared after fingerprint");
`endif

endmodule

`default_nettype wire
